[hw/rtl/pfb_pkg.sv]
// Shared types and constants for the page frame buffer column blitter.
package pfb_pkg;

   localparam int COLUMNS     = 128;
   localparam int PAGE_COUNT  = 8;
   localparam int ROW_COUNT   = PAGE_COUNT * 8;
   localparam int STORE_BYTES = PAGE_COUNT * COLUMNS;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int ROW_W       = 8;
   localparam int STREAM_BITS = 24;

   typedef enum logic [1:0] {
      OP_BLIT  = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_PAGE_RD,
      ST_PAGE_WR,
      ST_READ,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [6:0]  column;
      logic [5:0]  top_row;
      logic [4:0]  height;
      logic [2:0]  bit_offset;
      logic [23:0] pixel_bits;
      logic [2:0]  page_index;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       clipped;
   } rsp_type;

endpackage

[hw/rtl/pfb_page_merge.sv]
// Merges the run's pixels into one page byte of a column.
module pfb_page_merge (
   input  pfb_pkg::req_type                 req,
   input  logic [pfb_pkg::PAGE_W-1:0]       lpage,
   input  logic [7:0]                       old_byte,
   output logic [7:0]                       new_byte
);

   always_comb begin
      logic [pfb_pkg::ROW_W-1:0] row;
      logic [pfb_pkg::ROW_W-1:0] pos;
      logic [pfb_pkg::ROW_W-1:0] top;
      logic [pfb_pkg::ROW_W-1:0] run_end;
      logic                      hit;
      logic                      pix;
      top     = pfb_pkg::ROW_W'(req.top_row);
      run_end = top + pfb_pkg::ROW_W'(req.height);
      new_byte = old_byte;
      for (int b = 0; b < 8; b++) begin
         row = pfb_pkg::ROW_W'({lpage, 3'(b)});
         hit = (row >= top) && (row < run_end);
         pos = pfb_pkg::ROW_W'(req.bit_offset) + (row - top);
         // stream bit k sits at bit 23-k; past the stream end pixels are 0
         if (pos < pfb_pkg::ROW_W'(pfb_pkg::STREAM_BITS)) begin
            pix = req.pixel_bits[5'(pfb_pkg::STREAM_BITS - 1) - 5'(pos)];
         end else begin
            pix = 1'b0;
         end
         if (hit) begin
            new_byte[3'(7 - b)] = pix;
         end
      end
   end

endmodule

[hw/rtl/page_framebuffer_column_blitter_core.sv]
// Monochrome page frame buffer: column blit, byte read and store clear.
//
// Requests come in on req_valid/req_ready carrying a req_type; one response
// per request goes out on rsp_valid/rsp_ready as a rsp_type. The store is a
// single-port 1024 x 8 memory, one access per cycle, pages kept in reverse.
// A blit walks the page bytes it touches, each one read then merged and
// written back (up to 5 pages for a 31-row run, none when the height is
// zero, the column is past the store or the run starts below the last
// row). A clear sweeps one byte a cycle.
// The block works on one request at a time: req_ready is high only when it
// is idle. A finished response sits in the output register, so a new request
// is taken while the receiver stalls; the next response waits in its last
// cycle until the output register frees up.
// Reset runs the same clearing sweep; req_ready stays low
// through it, and no response is pending afterwards.
module page_framebuffer_column_blitter_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pfb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pfb_pkg::rsp_type rsp_data
);

   pfb_pkg::state_type             state_ff, state_in;
   pfb_pkg::req_type               req_ff, req_in;
   logic [pfb_pkg::PAGE_W-1:0]     lp_ff, lp_in;
   logic [pfb_pkg::PAGE_W-1:0]     last_lp_ff, last_lp_in;
   logic                           clip_ff, clip_in;
   logic [pfb_pkg::ADDR_W-1:0]     clr_ff, clr_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   pfb_pkg::rsp_type               rsp_data_ff, rsp_data_in;
   logic [7:0]                     rd_q_ff;

   logic [7:0]                     store_mem [pfb_pkg::STORE_BYTES];
   logic                           mem_we, mem_re;
   logic [pfb_pkg::ADDR_W-1:0]     mem_addr;
   logic [7:0]                     mem_wdata;
   logic [7:0]                     merged;

   logic [pfb_pkg::ROW_W-1:0]      run_end, last_row;
   logic                           col_ok, page_ok, run_live;
   logic [pfb_pkg::PAGE_W-1:0]     stored_page;

   pfb_page_merge u_merge (
      .req      (req_ff),
      .lpage    (lp_ff),
      .old_byte (rd_q_ff),
      .new_byte (merged)
   );

   assign req_ready = (state_ff == pfb_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      run_end  = pfb_pkg::ROW_W'(req_ff.top_row) + pfb_pkg::ROW_W'(req_ff.height);
      last_row = ((run_end > pfb_pkg::ROW_W'(pfb_pkg::ROW_COUNT)) ?
                  pfb_pkg::ROW_W'(pfb_pkg::ROW_COUNT) : run_end) - 1'b1;
      col_ok   = {2'b00, req_ff.column} < 9'(pfb_pkg::COLUMNS);
      page_ok  = {2'b00, req_ff.page_index} < 5'(pfb_pkg::PAGE_COUNT);
      run_live = (req_ff.height != 5'd0) && col_ok &&
                 (pfb_pkg::ROW_W'(req_ff.top_row) < pfb_pkg::ROW_W'(pfb_pkg::ROW_COUNT));
      stored_page = pfb_pkg::PAGE_W'(pfb_pkg::PAGE_COUNT - 1) - lp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfb_pkg::ST_CLEAR;
         clr_ff       <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      lp_ff       <= lp_in;
      last_lp_ff  <= last_lp_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_q_ff <= store_mem[mem_addr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      lp_in        = lp_ff;
      last_lp_in   = last_lp_ff;
      clip_in      = clip_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = pfb_pkg::ADDR_W'(32'(stored_page) * pfb_pkg::COLUMNS +
                                      32'(req_ff.column));
      mem_wdata    = merged;

      unique case (state_ff)
         pfb_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = 8'h00;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == pfb_pkg::ADDR_W'(pfb_pkg::STORE_BYTES - 1)) begin
               clr_in = '0;
               // the sweep after reset has no request behind it
               state_in = clip_ff ? pfb_pkg::ST_RESP : pfb_pkg::ST_IDLE;
            end
         end
         pfb_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               unique case (pfb_pkg::op_type'(req_data.opcode))
                  pfb_pkg::OP_BLIT:  state_in = pfb_pkg::ST_SETUP;
                  pfb_pkg::OP_READ:  state_in = pfb_pkg::ST_READ;
                  pfb_pkg::OP_CLEAR: begin
                     state_in = pfb_pkg::ST_CLEAR;
                     clr_in   = '0;
                     // marks a sweep that owes a response
                     clip_in  = 1'b1;
                  end
                  default:           state_in = pfb_pkg::ST_RESP;
               endcase
            end
         end
         pfb_pkg::ST_SETUP: begin
            clip_in    = (req_ff.height != 5'd0) &&
                         (run_end > pfb_pkg::ROW_W'(pfb_pkg::ROW_COUNT));
            lp_in      = pfb_pkg::PAGE_W'(req_ff.top_row >> 3);
            last_lp_in = pfb_pkg::PAGE_W'(last_row >> 3);
            state_in   = run_live ? pfb_pkg::ST_PAGE_RD : pfb_pkg::ST_RESP;
         end
         pfb_pkg::ST_PAGE_RD: begin
            mem_re   = 1'b1;
            state_in = pfb_pkg::ST_PAGE_WR;
         end
         pfb_pkg::ST_PAGE_WR: begin
            mem_we = 1'b1;
            lp_in  = lp_ff + 1'b1;
            state_in = (lp_ff == last_lp_ff) ? pfb_pkg::ST_RESP : pfb_pkg::ST_PAGE_RD;
         end
         pfb_pkg::ST_READ: begin
            mem_re   = 1'b1;
            mem_addr = pfb_pkg::ADDR_W'(32'(req_ff.page_index) * pfb_pkg::COLUMNS +
                                        32'(req_ff.column));
            state_in = pfb_pkg::ST_RESP;
         end
         pfb_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.read_data =
                  (req_ff.opcode == pfb_pkg::OP_READ && col_ok && page_ok) ? rd_q_ff : 8'h00;
               rsp_data_in.clipped = (req_ff.opcode == pfb_pkg::OP_BLIT) && clip_ff;
               clip_in  = 1'b0;
               state_in = pfb_pkg::ST_IDLE;
            end
         end
         default: state_in = pfb_pkg::ST_IDLE;
      endcase
   end

endmodule

[hw/rtl/pfb_port_checker.sv]
// Port-level checks for the column blitter, bound to the top level.
module pfb_port_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pfb_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one still in progress");

   a_sweep_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready && !rsp_valid)
      else $error("ready during clearing sweep after reset");

   a_rsp_then_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("response issued without returning to idle");

endmodule

bind page_framebuffer_column_blitter_core pfb_port_checker u_pfb_port_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[test/pfb_response_checker.sv]
`timescale 1ns / 100ps
// Response checker for the column blitter: shadow frame store, expected queue, compare.
module pfb_response_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  pfb_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  pfb_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               outstanding,
   output int               clips_seen,
   output int               nonzero_reads
);

   logic [7:0]       shadow_store [pfb_pkg::STORE_BYTES];
   pfb_pkg::rsp_type due_responses [$];
   pfb_pkg::rsp_type wanted;
   int               mismatches = 0;
   int               rsp_index = 0;
   int               clip_total = 0;
   int               nonzero_total = 0;

   // Applies one request to the shadow store and returns its response.
   function automatic pfb_pkg::rsp_type run_on_shadow_store(input pfb_pkg::req_type r);
      pfb_pkg::rsp_type result;
      int               row;
      int               slot;
      int               pos;
      logic             pix;
      result = '0;
      case (r.opcode)
         pfb_pkg::OP_BLIT: begin
            for (int i = 0; i < int'(r.height); i++) begin
               row = int'(r.top_row) + i;
               if (row >= pfb_pkg::ROW_COUNT) begin
                  result.clipped = 1'b1;
               end else if (int'(r.column) < pfb_pkg::COLUMNS) begin
                  // logical page p lives at stored page PAGE_COUNT-1-p
                  slot = (pfb_pkg::PAGE_COUNT - 1 - row / 8) * pfb_pkg::COLUMNS +
                         int'(r.column);
                  pos  = int'(r.bit_offset) + i;
                  pix  = (pos < pfb_pkg::STREAM_BITS) ?
                         r.pixel_bits[pfb_pkg::STREAM_BITS - 1 - pos] : 1'b0;
                  shadow_store[slot][7 - row % 8] = pix;
               end
            end
         end
         pfb_pkg::OP_READ: begin
            if (int'(r.column) < pfb_pkg::COLUMNS && int'(r.page_index) < pfb_pkg::PAGE_COUNT)
               result.read_data =
                  shadow_store[int'(r.page_index) * pfb_pkg::COLUMNS + int'(r.column)];
         end
         pfb_pkg::OP_CLEAR: begin
            foreach (shadow_store[a]) shadow_store[a] = '0;
         end
         default: ;
      endcase
      return result;
   endfunction

   task automatic report_failure(input string what);
      mismatches++;
      if (mismatches <= 10)
         $display("[%0t] response %0d: %s", $realtime, rsp_index, what);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (shadow_store[a]) shadow_store[a] = '0;
         due_responses.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_responses.size() == 0) begin
               report_failure($sformatf("unexpected, read_data %h clipped %b",
                                        rsp_data.read_data, rsp_data.clipped));
            end else begin
               wanted = due_responses.pop_front();
               if (rsp_data.read_data !== wanted.read_data ||
                   rsp_data.clipped !== wanted.clipped)
                  report_failure($sformatf("read_data exp %h got %h, clipped exp %b got %b",
                                           wanted.read_data, rsp_data.read_data,
                                           wanted.clipped, rsp_data.clipped));
            end
            rsp_index++;
         end
         if (req_valid && req_ready) begin
            wanted = run_on_shadow_store(req_data);
            if (wanted.clipped) clip_total++;
            if (wanted.read_data != 0) nonzero_total++;
            due_responses.push_back(wanted);
         end
      end
      error_count   <= mismatches;
      outstanding   <= due_responses.size();
      clips_seen    <= clip_total;
      nonzero_reads <= nonzero_total;
   end

endmodule

[test/tb_page_framebuffer_column_blitter_core.sv]
`timescale 1ns / 100ps
// Testbench top for the column blitter core: reset, stimulus, watchdog and verdict.
module tb_page_framebuffer_column_blitter_core;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         STALL_LIMIT  = 4000;
   localparam int         RANDOM_ITEMS = 930;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   pfb_pkg::req_type req_data = '0;
   logic             rsp_ready = 1'b0;
   logic             req_ready;
   logic             rsp_valid;
   pfb_pkg::rsp_type rsp_data;

   int error_count;
   int outstanding;
   int clips_seen;
   int nonzero_reads;
   int blits_sent = 0;
   int reads_sent = 0;
   int clears_sent = 0;
   int unused_sent = 0;
   int idle_cycles = 0;
   int ready_hold = 0;

   logic [6:0] hot_columns [4] = '{7'd0, 7'd41, 7'd64, 7'd127};

   always #5 clock = ~clock;

   page_framebuffer_column_blitter_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   pfb_response_checker response_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .outstanding   (outstanding),
      .clips_seen    (clips_seen),
      .nonzero_reads (nonzero_reads)
   );

   // receiver: ready stretches of random length, broken by short stalls
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_ready  <= 1'b0;
         ready_hold <= $urandom_range(0, 11);
      end else begin
         rsp_ready  <= 1'b1;
         ready_hold <= $urandom_range(0, 30);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no request or response moved for %0d cycles", idle_cycles);
         $display("tb_page_framebuffer_column_blitter_core NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic pfb_pkg::req_type make_req(input logic [1:0] op, input int col,
                                                 input int top, input int h, input int off,
                                                 input logic [23:0] bits, input int page);
      pfb_pkg::req_type r;
      r.opcode     = op;
      r.column     = 7'(col);
      r.top_row    = 6'(top);
      r.height     = 5'(h);
      r.bit_offset = 3'(off);
      r.pixel_bits = bits;
      r.page_index = 3'(page);
      return r;
   endfunction

   function automatic pfb_pkg::req_type random_request();
      pfb_pkg::req_type r;
      int               pick;
      r.column = ($urandom_range(0, 9) < 7) ? hot_columns[$urandom_range(0, 3)]
                                            : 7'($urandom_range(0, 127));
      r.top_row    = 6'($urandom_range(0, 63));
      r.bit_offset = 3'($urandom_range(0, 7));
      r.pixel_bits = 24'($urandom());
      r.page_index = 3'($urandom_range(0, 7));
      pick = $urandom_range(0, 19);
      if (pick == 0)
         r.height = '0;
      else if (pick < 4)
         r.height = 5'($urandom_range(17, 31));
      else
         r.height = 5'($urandom_range(1, 16));
      pick = $urandom_range(0, 199);
      if (pick < 120)      r.opcode = pfb_pkg::OP_BLIT;
      else if (pick < 192) r.opcode = pfb_pkg::OP_READ;
      else if (pick < 196) r.opcode = OP_UNUSED;
      else                 r.opcode = pfb_pkg::OP_CLEAR;
      return r;
   endfunction

   // holds valid until the request is taken; valid stays high for a following request
   task automatic send_request(input pfb_pkg::req_type r);
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      case (r.opcode)
         pfb_pkg::OP_BLIT:  blits_sent++;
         pfb_pkg::OP_READ:  reads_sent++;
         pfb_pkg::OP_CLEAR: clears_sent++;
         default:           unused_sent++;
      endcase
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_all_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      int               sent;
      int               burst;
      int               next_pause;
      pfb_pkg::req_type r;
      sent = 0;
      next_pause = 200;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_request(make_req(pfb_pkg::OP_READ,    0,  0,  0, 0, 24'h000000, 7));
      send_request(make_req(pfb_pkg::OP_BLIT,    0,  0, 16, 0, 24'hFFFFFF, 0));
      send_request(make_req(pfb_pkg::OP_READ,    0,  0,  0, 0, 24'h000000, 7));
      send_request(make_req(pfb_pkg::OP_READ,    0,  0,  0, 0, 24'h000000, 6));
      // partial byte: only rows 3..5 are touched
      send_request(make_req(pfb_pkg::OP_BLIT,    0,  3,  3, 0, 24'h000000, 0));
      send_request(make_req(pfb_pkg::OP_READ,    0,  0,  0, 0, 24'h000000, 7));
      send_request(make_req(pfb_pkg::OP_BLIT,  127, 56, 16, 7, 24'hA5A5A5, 0));
      send_request(make_req(pfb_pkg::OP_READ,  127,  0,  0, 0, 24'h000000, 0));
      send_request(make_req(pfb_pkg::OP_BLIT,  127, 63,  1, 0, 24'h800000, 0));
      send_request(make_req(pfb_pkg::OP_BLIT,  127, 63,  2, 0, 24'hFFFFFF, 0));
      pause_sender(3);
      // source runs dry past stream bit 23
      send_request(make_req(pfb_pkg::OP_BLIT,   64,  0, 31, 7, 24'hFFFFFF, 0));
      send_request(make_req(pfb_pkg::OP_READ,   64,  0,  0, 0, 24'h000000, 7));
      send_request(make_req(pfb_pkg::OP_READ,   64,  0,  0, 0, 24'h000000, 5));
      send_request(make_req(pfb_pkg::OP_READ,   64,  0,  0, 0, 24'h000000, 4));
      send_request(make_req(pfb_pkg::OP_BLIT,    5, 10,  0, 3, 24'hFFFFFF, 0));
      send_request(make_req(pfb_pkg::OP_BLIT,   64, 60, 31, 0, 24'hC3C3C3, 0));
      send_request(make_req(OP_UNUSED,         127, 63, 31, 7, 24'hFFFFFF, 7));
      send_request(make_req(pfb_pkg::OP_READ,    0,  0,  0, 0, 24'h000000, 0));
      wait_all_responses();
      send_request(make_req(pfb_pkg::OP_CLEAR,   0,  0,  0, 0, 24'h000000, 0));
      send_request(make_req(pfb_pkg::OP_READ,    0,  0,  0, 0, 24'h000000, 6));
      send_request(make_req(pfb_pkg::OP_READ,  127,  0,  0, 0, 24'h000000, 0));
      send_request(make_req(pfb_pkg::OP_BLIT,   85, 42, 21, 5, 24'h5A5A5A, 2));
      send_request(make_req(pfb_pkg::OP_READ,   85,  0,  0, 0, 24'h000000, 2));
      wait_all_responses();

      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 16);
         repeat (burst) begin
            r = random_request();
            send_request(r);
            if (r.opcode != OP_UNUSED) sent++;
         end
         case ($urandom_range(0, 5))
            0, 1:    ;
            2:       pause_sender($urandom_range(10, 30));
            default: pause_sender($urandom_range(1, 8));
         endcase
         if (sent >= next_pause) begin
            wait_all_responses();
            next_pause += 200;
         end
      end

      wait_all_responses();
      repeat (20) @(posedge clock);
      $display("covered %0d blits (%0d ran past the last row), %0d reads (%0d nonzero)",
               blits_sent, clips_seen, reads_sent, nonzero_reads);
      $display("also %0d store clears and %0d unused-opcode requests; %0d mismatches",
               clears_sent, unused_sent, error_count);
      if (error_count == 0 && outstanding == 0 && rsp_valid !== 1'b1)
         $display("tb_page_framebuffer_column_blitter_core OK");
      else
         $display("tb_page_framebuffer_column_blitter_core NOT OK");
      $finish;
   end

endmodule

[page_framebuffer_column_blitter_core.f]
hw/rtl/pfb_pkg.sv
hw/rtl/pfb_page_merge.sv
hw/rtl/page_framebuffer_column_blitter_core.sv
hw/rtl/pfb_port_checker.sv
test/pfb_response_checker.sv
test/tb_page_framebuffer_column_blitter_core.sv
